>>> rtl/bts_pkg.sv
package bts_pkg;

   localparam int MAX_DIMENSION = 256;
   localparam int DIM_BITS      = $clog2(MAX_DIMENSION);
   localparam int DIMW          = DIM_BITS + 1;
   localparam int WEIGHT_BITS   = 8;
   localparam int FRAC_BITS     = 16;
   localparam int SCALE_BITS    = 16;
   localparam int PROD_BITS     = FRAC_BITS + SCALE_BITS;
   localparam int WT_BITS       = 2 * WEIGHT_BITS + 1;
   localparam int ADDR_BITS     = 2 * DIM_BITS;
   localparam int STORE_DEPTH   = MAX_DIMENSION * MAX_DIMENSION;
   localparam int TEXEL_BITS    = 24;
   localparam int CH_BITS       = 8;
   localparam int MUL_BITS      = WT_BITS + CH_BITS;
   localparam int ACC_BITS      = MUL_BITS + 2;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_HSCALE = 2'd2,
      REG_VSCALE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]    lo;
      logic [DIM_BITS-1:0]    hi;
      logic [WEIGHT_BITS-1:0] weight;
   } axis_type;

   function automatic logic [DIMW-1:0] eff_dim(input logic [DIMW-1:0] d);
      logic [DIMW-1:0] r;
      r = d;
      if (d == '0) r = DIMW'(1);
      else if (d > DIMW'(MAX_DIMENSION)) r = DIMW'(MAX_DIMENSION);
      return r;
   endfunction

endpackage

>>> rtl/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler with wrap addressing. A write word (tuser 0) stores
// one RGB texel at column/row; a sample word (tuser 1) returns one filtered RGB
// word. The pipeline takes one word per cycle when the result side is not
// stalled; a sample's result passes through the input register, coordinate
// multiply, address, texel read (weight products in parallel), texel multiply
// and sum stages. A stall on the result side holds the whole pipeline. The
// texel store is four full copies, one per bilinear tap, so four texels are
// read each cycle; writes go to all copies at the read stage, so a sample sees
// every earlier write. Store contents are undefined until written.
module bilinear_texture_sampler_unit import bts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // column[7:0] row[15:8] red[23:16] green[31:24] blue[39:32]
   // coord_u[71:40] coord_v[103:72]
   input  logic [103:0] req_tdata,
   // operation[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // red[7:0] green[15:8] blue[23:16]
   output logic [23:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   logic [DIMW-1:0]       width_ff, height_ff;
   logic [SCALE_BITS-1:0] hscale_ff, vscale_ff;
   logic                  advance;

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                  s4_valid_ff, s5_valid_ff, s6_valid_ff;
   op_type                s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff, s5_op_ff;
   logic [DIM_BITS-1:0]   s1_col_ff, s1_row_ff, s2_col_ff, s2_row_ff;
   logic [TEXEL_BITS-1:0] s1_rgb_ff, s2_rgb_ff, s3_rgb_ff;
   logic [FRAC_BITS-1:0]  s1_u_ff, s1_v_ff;
   logic [PROD_BITS-1:0]  s2_pu_ff, s2_pv_ff;
   logic [ADDR_BITS-1:0]  s3_addr_ff [4];
   logic [ADDR_BITS-1:0]  s3_waddr_ff;
   logic [WEIGHT_BITS-1:0] s3_wx_ff, s3_wy_ff;
   logic [WT_BITS-1:0]    s4_wt_ff [4];
   logic [TEXEL_BITS-1:0] tex [4];
   logic [MUL_BITS-1:0]   s5_mul_ff [3][4];
   logic [23:0]           s6_rgb_ff;

   axis_type              ax_u, ax_v;
   logic [DIMW-1:0]       w_eff, h_eff;
   logic [DIMW-1:0]       r0, r1;
   logic                  wr_en;

   function automatic logic [CH_BITS-1:0] sum_ch(input logic [MUL_BITS-1:0] a,
                                                 input logic [MUL_BITS-1:0] b,
                                                 input logic [MUL_BITS-1:0] c,
                                                 input logic [MUL_BITS-1:0] d);
      logic [ACC_BITS-1:0] acc;
      acc = ACC_BITS'(a) + ACC_BITS'(b) + ACC_BITS'(c) + ACC_BITS'(d)
            + ACC_BITS'(1 << (2*WEIGHT_BITS-1));
      // weights sum to one, so the top bits are always zero
      return acc[2*WEIGHT_BITS +: CH_BITS];
   endfunction

   assign advance    = !s6_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = s6_valid_ff;
   assign rsp_tdata  = s6_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIMW'(MAX_DIMENSION);
         height_ff <= DIMW'(MAX_DIMENSION);
         hscale_ff <= '1;
         vscale_ff <= '1;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_WIDTH:  width_ff  <= csr_data[DIMW-1:0];
            REG_HEIGHT: height_ff <= csr_data[DIMW-1:0];
            REG_HSCALE: hscale_ff <= csr_data;
            REG_VSCALE: vscale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff && (s5_op_ff == OP_SAMPLE);
      end
   end

   bts_axis u_axis_u (.prod(s2_pu_ff), .dim(w_eff), .axis(ax_u));
   bts_axis u_axis_v (.prod(s2_pv_ff), .dim(h_eff), .axis(ax_v));

   always_comb begin
      w_eff = eff_dim(width_ff);
      h_eff = eff_dim(height_ff);
      r0    = h_eff - DIMW'(1) - DIMW'(ax_v.lo);
      r1    = h_eff - DIMW'(1) - DIMW'(ax_v.hi);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff  <= op_type'(req_tuser);
         s1_col_ff <= req_tdata[7:0];
         s1_row_ff <= req_tdata[15:8];
         s1_rgb_ff <= {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};
         s1_u_ff   <= req_tdata[55:40];
         s1_v_ff   <= req_tdata[87:72];

         s2_op_ff  <= s1_op_ff;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         s2_rgb_ff <= s1_rgb_ff;
         s2_pu_ff  <= s1_u_ff * hscale_ff;
         s2_pv_ff  <= s1_v_ff * vscale_ff;

         s3_op_ff      <= s2_op_ff;
         s3_rgb_ff     <= s2_rgb_ff;
         s3_waddr_ff   <= {s2_row_ff, s2_col_ff};
         s3_addr_ff[0] <= {r0[DIM_BITS-1:0], ax_u.lo};
         s3_addr_ff[1] <= {r1[DIM_BITS-1:0], ax_u.lo};
         s3_addr_ff[2] <= {r0[DIM_BITS-1:0], ax_u.hi};
         s3_addr_ff[3] <= {r1[DIM_BITS-1:0], ax_u.hi};
         s3_wx_ff      <= ax_u.weight;
         s3_wy_ff      <= ax_v.weight;

         s4_op_ff     <= s3_op_ff;
         s4_wt_ff[0]  <= WT_BITS'(DIMW'(1 << WEIGHT_BITS) - DIMW'(s3_wx_ff))
                         * WT_BITS'(DIMW'(1 << WEIGHT_BITS) - DIMW'(s3_wy_ff));
         s4_wt_ff[1]  <= WT_BITS'(DIMW'(1 << WEIGHT_BITS) - DIMW'(s3_wx_ff))
                         * WT_BITS'(s3_wy_ff);
         s4_wt_ff[2]  <= WT_BITS'(s3_wx_ff)
                         * WT_BITS'(DIMW'(1 << WEIGHT_BITS) - DIMW'(s3_wy_ff));
         s4_wt_ff[3]  <= WT_BITS'(s3_wx_ff) * WT_BITS'(s3_wy_ff);

         s5_op_ff <= s4_op_ff;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               s5_mul_ff[c][k] <= MUL_BITS'(s4_wt_ff[k])
                                  * MUL_BITS'(tex[k][TEXEL_BITS-1-CH_BITS*c -: CH_BITS]);
            end
         end

         for (int c = 0; c < 3; c++) begin
            s6_rgb_ff[CH_BITS*c +: CH_BITS] <=
               sum_ch(s5_mul_ff[c][0], s5_mul_ff[c][1], s5_mul_ff[c][2],
                      s5_mul_ff[c][3]);
         end
      end
   end

   assign wr_en = advance && s3_valid_ff && (s3_op_ff == OP_WRITE);

   for (genvar k = 0; k < 4; k++) begin : g_copy
      bts_ram #(
         .WIDTH(TEXEL_BITS),
         .DEPTH(STORE_DEPTH)
      ) u_ram (
         .clock  (clock),
         .wr_en  (wr_en),
         .wr_addr(s3_waddr_ff),
         .wr_data(s3_rgb_ff),
         .rd_en  (advance),
         .rd_addr(s3_addr_ff[k]),
         .rd_data(tex[k])
      );
   end

endmodule

>>> rtl/bts_ram.sv
module bts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bts_axis.sv
module bts_axis import bts_pkg::*; (
   input  logic [PROD_BITS-1:0] prod,
   input  logic [DIMW-1:0]      dim,
   output axis_type             axis
);

   logic [DIMW-1:0] idx0;
   logic [DIMW-1:0] idx1;
   logic [DIMW-1:0] idx2;
   logic [DIMW-1:0] up;

   always_comb begin
      idx0 = DIMW'(prod[PROD_BITS-1 -: DIM_BITS]);
      idx1 = (idx0 >= dim) ? idx0 - dim : idx0;
      // scale beyond twice the dimension: pin to the last texel
      idx2 = (idx1 >= dim) ? dim - DIMW'(1) : idx1;
      up   = idx2 + DIMW'(1);
      if (up >= dim) up = '0;
      axis.lo     = idx2[DIM_BITS-1:0];
      axis.hi     = up[DIM_BITS-1:0];
      axis.weight = prod[PROD_BITS-DIM_BITS-1 -: WEIGHT_BITS];
   end

endmodule

>>> rtl/bts_checker.sv
module bts_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [103:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [15:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled while output side is free");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind bilinear_texture_sampler_unit bts_checker u_bts_checker (.*);

>>> sim/bilinear_texture_sampler_unit_tb.sv
`timescale 1ns / 1ps

module bilinear_texture_sampler_unit_tb import bts_pkg::*;;

   typedef struct {
      op_type      op;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [23:0] rgb;
      logic [31:0] u;
      logic [31:0] v;
      bit          typed;
      logic [23:0] want;
   } stim_row_type;

   typedef struct {
      logic [8:0]  width;
      logic [8:0]  height;
      logic [15:0] hscale;
      logic [15:0] vscale;
   } tex_setting_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   logic [23:0]  texel_copy [STORE_DEPTH];
   bit           written [STORE_DEPTH];
   logic [8:0]   cur_width = 9'd256;
   logic [8:0]   cur_height = 9'd256;
   logic [15:0]  cur_hscale = 16'hFFFF;
   logic [15:0]  cur_vscale = 16'hFFFF;
   logic [23:0]  pending_colors [$];
   int           send_idle = 0;
   int           recv_idle = 0;
   int           errors = 0;
   int           sent = 0;

   bilinear_texture_sampler_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [8:0] clamp_dim(logic [8:0] d);
      if (d == 9'd0) return 9'd1;
      if (d > 9'd256) return 9'd256;
      return d;
   endfunction

   // lower index, upper index and weight for one axis
   function automatic void split_coord(input logic [31:0] c, input logic [15:0] scale,
                                       input logic [8:0] dim, output logic [8:0] lo,
                                       output logic [8:0] hi, output logic [7:0] wt);
      logic [31:0] prod;
      prod = c[15:0] * scale;
      lo = {1'b0, prod[31:24]};
      wt = prod[23:16];
      if (lo >= dim) lo = lo - dim;
      if (lo >= dim) lo = dim - 9'd1;
      hi = lo + 9'd1;
      if (hi >= dim) hi = hi - dim;
   endfunction

   function automatic logic [23:0] filtered_color(logic [31:0] u, logic [31:0] v);
      logic [8:0]  w, h, xl, xh, yl, yh, r0, r1;
      logic [7:0]  wx, wy;
      logic [31:0] tw [4];
      logic [23:0] tx [4];
      logic [31:0] acc;
      logic [23:0] res;
      w = clamp_dim(cur_width);
      h = clamp_dim(cur_height);
      split_coord(u, cur_hscale, w, xl, xh, wx);
      split_coord(v, cur_vscale, h, yl, yh, wy);
      r0 = h - 9'd1 - yl;
      r1 = h - 9'd1 - yh;
      tw[0] = (32'd256 - wx) * (32'd256 - wy);
      tw[1] = (32'd256 - wx) * wy;
      tw[2] = wx * (32'd256 - wy);
      tw[3] = wx * wy;
      tx[0] = texel_copy[{r0[7:0], xl[7:0]}];
      tx[1] = texel_copy[{r1[7:0], xl[7:0]}];
      tx[2] = texel_copy[{r0[7:0], xh[7:0]}];
      tx[3] = texel_copy[{r1[7:0], xh[7:0]}];
      for (int ch = 0; ch < 3; ch++) begin
         acc = 32'd32768;
         for (int k = 0; k < 4; k++)
            acc += tw[k] * tx[k][16-8*ch +: 8];
         acc = acc >> 16;
         res[16-8*ch +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
      end
      return res;
   endfunction

   // rgb packed red high, as in the store
   task automatic send_word(op_type op, logic [7:0] col, logic [7:0] row, logic [23:0] rgb,
                            logic [31:0] u, logic [31:0] v);
      logic [23:0] out_rgb;
      req_tuser <= op;
      req_tdata <= {v, u, rgb[7:0], rgb[15:8], rgb[23:16], row, col};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (op == OP_WRITE) begin
         texel_copy[{row, col}] = rgb;
         written[{row, col}] = 1'b1;
      end else begin
         out_rgb = filtered_color(u, v);
         pending_colors.push_back(out_rgb);
      end
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // load any texel a sample would read that has not been written yet
   task automatic fill_taps(logic [31:0] u, logic [31:0] v);
      logic [8:0]  w, h, xl, xh, yl, yh, r0, r1;
      logic [7:0]  wx, wy;
      logic [15:0] taps [4];
      w = clamp_dim(cur_width);
      h = clamp_dim(cur_height);
      split_coord(u, cur_hscale, w, xl, xh, wx);
      split_coord(v, cur_vscale, h, yl, yh, wy);
      r0 = h - 9'd1 - yl;
      r1 = h - 9'd1 - yh;
      taps[0] = {r0[7:0], xl[7:0]};
      taps[1] = {r1[7:0], xl[7:0]};
      taps[2] = {r0[7:0], xh[7:0]};
      taps[3] = {r1[7:0], xh[7:0]};
      for (int k = 0; k < 4; k++) begin
         if (!written[taps[k]])
            send_word(OP_WRITE, taps[k][7:0], taps[k][15:8], 24'($urandom),
                      $urandom, $urandom);
      end
   endtask

   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_WIDTH:  cur_width = val[8:0];
         REG_HEIGHT: cur_height = val[8:0];
         REG_HSCALE: cur_hscale = val;
         REG_VSCALE: cur_vscale = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colors.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_colors.pop_front();
            // rsp_tdata is red low; want is red high
            if (rsp_tdata[7:0] !== want[23:16]) begin
               $display("%0t: red expected %h actual %h", $time, want[23:16], rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[15:8] !== want[15:8]) begin
               $display("%0t: green expected %h actual %h", $time, want[15:8],
                        rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[23:16] !== want[7:0]) begin
               $display("%0t: blue expected %h actual %h", $time, want[7:0],
                        rsp_tdata[23:16]);
               errors++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      stim_row_type    plan [$];
      tex_setting_type settings [6];
      logic [23:0]     head;
      logic [31:0]     u, v;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset scales: zero fraction hits column 0, flipped row 255 exactly
      plan.push_back('{OP_WRITE, 8'd0, 8'd255, 24'hFF0080, 32'hFFFFFFFF, 32'h0, 0, 0});
      plan.push_back('{OP_SAMPLE, 8'hFF, 8'hFF, 24'hFFFFFF, 32'h0, 32'h0, 1, 24'hFF0080});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'h7FFF0000, 32'h80000000,
                       1, 24'hFF0080});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'hFFFF0000, 32'h00010000,
                       1, 24'hFF0080});
      plan.push_back('{OP_WRITE, 8'd255, 8'd0, 24'h000000, 32'h0, 32'h0, 0, 0});
      plan.push_back('{OP_WRITE, 8'd255, 8'd255, 24'hFFFFFF, 32'h0, 32'h0, 0, 0});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'h0000FFFF, 32'h0000FFFF, 0, 0});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'h80008000, 32'h7FFF7FFF, 0, 0});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'hFFFFFFFF, 32'h00000001, 0, 0});
      plan.push_back('{OP_SAMPLE, 8'h0, 8'h0, 24'h0, 32'h12345678, 32'h9ABCDEF0, 0, 0});
      foreach (plan[i]) begin
         if (plan[i].op == OP_SAMPLE)
            fill_taps(plan[i].u, plan[i].v);
         if (plan[i].typed && plan[i].op == OP_SAMPLE) begin
            head = filtered_color(plan[i].u, plan[i].v);
            if (head !== plan[i].want) begin
               $display("%0t: table row %0d expected %h actual %h", $time, i,
                        plan[i].want, head);
               errors++;
            end
         end
         send_word(plan[i].op, plan[i].col, plan[i].row, plan[i].rgb, plan[i].u, plan[i].v);
      end
      drain();

      settings[0] = '{9'd1, 9'd1, 16'd0, 16'd0};
      settings[1] = '{9'd511, 9'd0, 16'hFFFF, 16'hFFFF};
      settings[2] = '{9'd256, 9'd256, 16'h0100, 16'h0100};
      settings[3] = '{9'd37, 9'd200, 16'($urandom), 16'($urandom)};
      settings[4] = '{9'd0, 9'd300, 16'd12345, 16'd500};
      settings[5] = '{9'd100, 9'd3, 16'hFFFF, 16'd1};

      for (int s = 0; s < 6; s++) begin
         send_idle = (s < 2) ? 22 : (s < 4) ? 58 : 0;
         recv_idle = (s < 2) ? 58 : (s < 4) ? 22 : 0;
         write_reg(REG_WIDTH, {7'd0, settings[s].width});
         write_reg(REG_HEIGHT, {7'd0, settings[s].height});
         write_reg(REG_HSCALE, settings[s].hscale);
         write_reg(REG_VSCALE, settings[s].vscale);
         while (sent < 40 + (s + 1) * 235) begin
            u = $urandom;
            v = $urandom;
            // coordinate fractions near the wrap points
            if ($urandom_range(9) == 0) u[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(9) == 0) v[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(99) < 30) begin
               send_word(OP_WRITE, 8'($urandom), 8'($urandom), 24'($urandom), u, v);
            end else begin
               fill_taps(u, v);
               send_word(OP_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), u, v);
            end
         end
         drain();
      end

      if (errors == 0 && pending_colors.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
